### rtl/core/crc8bpf_pkg.sv
// Package for the CRC-8 byte pair framer.
// Holds the item types, register codes and the CRC-8 byte update function.
// Depends on nothing.
package crc8bpf_pkg;

   localparam logic [7:0] CrcPoly = 8'h07;
   localparam logic [7:0] ReadBit = 8'h01;
   localparam logic [7:0] TopBit  = 8'h80;

   localparam int CsrIndexWidth = 1;
   localparam int CsrDataWidth  = 8;

   localparam logic [CsrIndexWidth-1:0] CsrDeviceAddress = 1'd0;
   localparam logic [CsrIndexWidth-1:0] CsrCrcEnable     = 1'd1;

   localparam logic [6:0] DeviceAddressReset = 7'd0;
   localparam logic       CrcEnableReset     = 1'b1;

   typedef struct packed {
      logic       kind;
      logic       first_byte;
      logic       last_byte;
      logic [7:0] register_address;
      logic [7:0] payload_byte;
      logic [7:0] received_crc;
   } req_type;

   typedef struct packed {
      logic [7:0] data_out;
      logic [7:0] crc_out;
      logic       crc_match;
      logic       fault;
      logic       end_of_run;
   } rsp_type;

   typedef struct packed {
      logic [6:0] device_address;
      logic       crc_enable;
   } cfg_type;

   function automatic logic [7:0] crc_feed(input logic [7:0] crc_in,
                                           input logic [7:0] byte_in);
      logic [7:0] c;
      c = crc_in ^ byte_in;
      for (int b = 0; b < 8; b++) begin
         if ((c & TopBit) != 8'd0) begin
            c = (c << 1) ^ CrcPoly;
         end else begin
            c = c << 1;
         end
      end
      return c;
   endfunction

endpackage

### rtl/core/crc8bpf_csr.sv
// Configuration registers of the CRC-8 byte pair framer.
// Depends on crc8bpf_pkg for the register codes and the configuration type.
module crc8bpf_csr (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [crc8bpf_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [crc8bpf_pkg::CsrDataWidth-1:0]    csr_data,
   output crc8bpf_pkg::cfg_type                    cfg
);

   logic [6:0] device_address_ff;
   logic       crc_enable_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         device_address_ff <= crc8bpf_pkg::DeviceAddressReset;
         crc_enable_ff     <= crc8bpf_pkg::CrcEnableReset;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            crc8bpf_pkg::CsrDeviceAddress: begin
               device_address_ff <= csr_data[6:0];
            end
            crc8bpf_pkg::CsrCrcEnable: begin
               crc_enable_ff <= csr_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   assign cfg.device_address = device_address_ff;
   assign cfg.crc_enable     = crc_enable_ff;

endmodule

### rtl/core/crc8bpf_crc.sv
// CRC-8 computation and check for one item of the byte pair framer.
// Depends on crc8bpf_pkg for the item types and the byte update function.
module crc8bpf_crc (
   input  crc8bpf_pkg::cfg_type cfg,
   input  crc8bpf_pkg::req_type item,
   output logic [7:0]           crc_out,
   output logic                 crc_match
);

   logic [7:0] addr_w;
   logic [7:0] addr_r;
   logic [7:0] crc_head;
   logic [7:0] crc_pre;
   logic [7:0] crc_full;

   assign addr_w = {cfg.device_address, 1'b0};
   assign addr_r = addr_w | crc8bpf_pkg::ReadBit;

   always_comb begin
      crc_head = crc8bpf_pkg::crc_feed(crc8bpf_pkg::crc_feed(8'd0, addr_w),
                                       item.register_address);
      if (!item.first_byte) begin
         crc_pre = 8'd0;
      end else if (item.kind) begin
         crc_pre = crc8bpf_pkg::crc_feed(crc_head, addr_r);
      end else begin
         crc_pre = crc_head;
      end
      crc_full  = crc8bpf_pkg::crc_feed(crc_pre, item.payload_byte);
      crc_out   = cfg.crc_enable ? crc_full : 8'd0;
      crc_match = !(cfg.crc_enable && item.kind && (crc_full != item.received_crc));
   end

endmodule

### rtl/core/crc8_byte_pair_framer.sv
// Top level of the CRC-8 byte pair framer.
// Depends on crc8bpf_pkg, crc8bpf_csr and crc8bpf_crc.
//
// Each item carries one payload byte and gives one result item with the
// byte, its CRC-8 (polynomial 0x07, initial value 0), a match flag for
// received read bytes and a fault flag that stays set until the transaction
// ends. The block takes one item per cycle while its output is not stalled:
// an item goes into an input register, the CRC over up to four bytes is
// formed from that register and lands in the result register when that is free;
// the result is offered from there. The fault flag of a transaction is tracked as
// items move into the result register. Configuration writes complete at once.
module crc8_byte_pair_framer (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  crc8bpf_pkg::req_type                    req_data,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output crc8bpf_pkg::rsp_type                    rsp_data,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [crc8bpf_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [crc8bpf_pkg::CsrDataWidth-1:0]    csr_data
);

   crc8bpf_pkg::cfg_type cfg;
   crc8bpf_pkg::req_type item_ff;
   crc8bpf_pkg::rsp_type rsp_ff;
   crc8bpf_pkg::rsp_type rsp_in;
   logic                 item_valid_ff;
   logic                 rsp_valid_ff;
   logic                 fault_seen_ff;
   logic                 fault_seen_in;
   logic                 out_free;
   logic                 advance;
   logic [7:0]           crc_value;
   logic                 crc_match;
   logic                 fault_now;

   crc8bpf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   crc8bpf_crc u_crc (
      .cfg       (cfg),
      .item      (item_ff),
      .crc_out   (crc_value),
      .crc_match (crc_match)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = item_valid_ff && out_free;
   assign req_ready = !item_valid_ff || out_free;

   always_comb begin
      fault_now            = (!item_ff.first_byte && fault_seen_ff) || !crc_match;
      fault_seen_in        = fault_now && !item_ff.last_byte;
      rsp_in.data_out      = item_ff.payload_byte;
      rsp_in.crc_out       = crc_value;
      rsp_in.crc_match     = crc_match;
      rsp_in.fault         = fault_now;
      rsp_in.end_of_run    = item_ff.last_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         fault_seen_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            item_valid_ff <= req_valid;
         end
         if (out_free) begin
            rsp_valid_ff <= item_valid_ff;
         end
         if (advance) begin
            fault_seen_ff <= fault_seen_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### rtl/core/crc8bpf_checker.sv
// Port checker for the CRC-8 byte pair framer, bound to the top level.
// Depends on crc8bpf_pkg for the item types.
module crc8bpf_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input crc8bpf_pkg::rsp_type rsp_data,
   input logic                 csr_valid,
   input logic                 csr_ready
);

   // A stalled result item holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed while stalled");

   // A failed check always shows as a fault.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.crc_match |-> rsp_data.fault)
      else $error("mismatch without fault");

   // With no result waiting, the block must take a new item.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");

   // Reset leaves no result item behind.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result item after reset");

   // Configuration writes are never held off.
   assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("configuration write stalled");

endmodule

bind crc8_byte_pair_framer crc8bpf_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data),
   .csr_valid (csr_valid),
   .csr_ready (csr_ready)
);

### tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for crc8_byte_pair_framer: framed and checked bytes
// are predicted per item and compared with each result item.
// Depends on crc8bpf_pkg and crc8_byte_pair_framer.
module tb;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_READ  = 1'b1;

   logic                                  clock = 1'b0;
   logic                                  reset = 1'b1;
   logic                                  req_valid = 1'b0;
   logic                                  req_ready;
   crc8bpf_pkg::req_type                  req_data = '0;
   logic                                  rsp_valid;
   logic                                  rsp_ready = 1'b0;
   crc8bpf_pkg::rsp_type                  rsp_data;
   logic                                  csr_valid = 1'b0;
   logic                                  csr_ready;
   logic [crc8bpf_pkg::CsrIndexWidth-1:0] csr_index = '0;
   logic [crc8bpf_pkg::CsrDataWidth-1:0]  csr_data = '0;

   crc8bpf_pkg::req_type pending_bytes[$];
   crc8bpf_pkg::rsp_type expected_frames[$];
   crc8bpf_pkg::rsp_type framed;
   crc8bpf_pkg::rsp_type wanted;

   logic [6:0] cfg_dev = crc8bpf_pkg::DeviceAddressReset;
   logic       cfg_crc_on = crc8bpf_pkg::CrcEnableReset;
   logic       txn_fault = 1'b0;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_left = 0;
   int rsp_count = 0;
   int mismatch_count = 0;

   crc8_byte_pair_framer uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   // Bit-serial CRC-8, most significant bit first.
   function automatic logic [7:0] crc8_shift(logic [7:0] acc, logic [7:0] din);
      logic [7:0] r;
      logic       fb;
      r = acc;
      for (int i = 7; i >= 0; i--) begin
         fb = r[7] ^ din[i];
         r = {r[6:0], 1'b0} ^ (fb ? crc8bpf_pkg::CrcPoly : 8'h00);
      end
      return r;
   endfunction

   function automatic logic [7:0] frame_crc(crc8bpf_pkg::req_type it,
                                            logic [6:0] dev, logic en);
      logic [7:0] wr_addr;
      logic [7:0] c;
      wr_addr = {dev, 1'b0};
      c = 8'h00;
      if (!en) begin
         return 8'h00;
      end
      if (it.first_byte) begin
         c = crc8_shift(c, wr_addr);
         c = crc8_shift(c, it.register_address);
         if (it.kind == KIND_READ) begin
            c = crc8_shift(c, wr_addr | crc8bpf_pkg::ReadBit);
         end
      end
      return crc8_shift(c, it.payload_byte);
   endfunction

   // The received CRC is the correct one for the current settings xor flip.
   task automatic push_item(logic kind, logic is_first, logic is_last,
                            logic [7:0] reg_byte, logic [7:0] data, logic [7:0] flip);
      crc8bpf_pkg::req_type it;
      it.kind             = kind;
      it.first_byte       = is_first;
      it.last_byte        = is_last;
      it.register_address = reg_byte;
      it.payload_byte     = data;
      it.received_crc     = 8'h00;
      it.received_crc     = frame_crc(it, cfg_dev, cfg_crc_on) ^ flip;
      pending_bytes.push_back(it);
   endtask

   task automatic queue_random_traffic(int n_items);
      int         count;
      int         len;
      logic       rd;
      logic [7:0] flip;
      logic [31:0] noise;
      count = 0;
      while (count < n_items) begin
         if ($urandom_range(99) < 12) begin
            noise = $urandom;
            pending_bytes.push_back(noise[$bits(crc8bpf_pkg::req_type)-1:0]);
            count++;
         end else begin
            len = ($urandom_range(3) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 3);
            rd = $urandom_range(1);
            for (int i = 0; i < len; i++) begin
               flip = 8'h00;
               if ($urandom_range(3) == 0) begin
                  flip = ($urandom_range(2) == 0) ? 8'($urandom) : 8'(1 << $urandom_range(7));
               end
               push_item(($urandom_range(9) == 0) ? ~rd : rd, i == 0, i == len - 1,
                         8'($urandom), 8'($urandom), flip);
               count++;
            end
         end
      end
   endtask

   task automatic write_csr(logic [crc8bpf_pkg::CsrIndexWidth-1:0] idx,
                            logic [crc8bpf_pkg::CsrDataWidth-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == crc8bpf_pkg::CsrDeviceAddress) begin
         cfg_dev = val[6:0];
      end else begin
         cfg_crc_on = val[0];
      end
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (pending_bytes.size() != 0 || req_valid || expected_frames.size() != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic compare_field(string field, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h, got %h", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            if (req_data.first_byte) begin
               txn_fault = 1'b0;
            end
            framed.data_out   = req_data.payload_byte;
            framed.crc_out    = frame_crc(req_data, cfg_dev, cfg_crc_on);
            framed.crc_match  = !(cfg_crc_on && req_data.kind == KIND_READ &&
                                  framed.crc_out != req_data.received_crc);
            if (!framed.crc_match) begin
               txn_fault = 1'b1;
            end
            framed.fault      = txn_fault;
            framed.end_of_run = req_data.last_byte;
            if (req_data.last_byte) begin
               txn_fault = 1'b0;
            end
            expected_frames.push_back(framed);
         end
         if (!req_valid || req_ready) begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= pending_bytes.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_frames.size() == 0) begin
               $display("%0t: unexpected item, data_out %h", $time, rsp_data.data_out);
               mismatch_count++;
            end else begin
               wanted = expected_frames.pop_front();
               compare_field("data_out", wanted.data_out, rsp_data.data_out);
               compare_field("crc_out", wanted.crc_out, rsp_data.crc_out);
               compare_field("crc_match", 8'(wanted.crc_match), 8'(rsp_data.crc_match));
               compare_field("fault", 8'(wanted.fault), 8'(rsp_data.fault));
               compare_field("end_of_run", 8'(wanted.end_of_run),
                             8'(rsp_data.end_of_run));
            end
            rsp_count++;
            if (rsp_count % 500 == 250) begin
               hold_left = 48;
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Bit 7 of the address write must be dropped.
      write_csr(crc8bpf_pkg::CsrDeviceAddress, 8'h80);
      write_csr(crc8bpf_pkg::CsrCrcEnable, 8'h01);
      push_item(KIND_WRITE, 1'b1, 1'b1, 8'h00, 8'h00, 8'h00);
      push_item(KIND_WRITE, 1'b1, 1'b1, 8'hFF, 8'hFF, 8'hFF);
      push_item(KIND_READ, 1'b1, 1'b1, 8'h00, 8'h00, 8'h00);
      push_item(KIND_READ, 1'b1, 1'b1, 8'hFF, 8'hFF, 8'h00);
      push_item(KIND_READ, 1'b1, 1'b1, 8'h5A, 8'hC3, 8'hFF);
      push_item(KIND_WRITE, 1'b1, 1'b0, 8'h12, 8'hA5, 8'h00);
      push_item(KIND_WRITE, 1'b0, 1'b0, 8'h34, 8'h5A, 8'h00);
      push_item(KIND_WRITE, 1'b0, 1'b1, 8'h56, 8'h80, 8'h00);
      push_item(KIND_READ, 1'b1, 1'b0, 8'h9C, 8'h01, 8'h00);
      push_item(KIND_READ, 1'b0, 1'b0, 8'h00, 8'h7F, 8'h01);
      push_item(KIND_READ, 1'b0, 1'b1, 8'h00, 8'hFE, 8'h00);
      push_item(KIND_READ, 1'b1, 1'b1, 8'h33, 8'h44, 8'h00);
      push_item(KIND_READ, 1'b1, 1'b0, 8'hE0, 8'h0F, 8'h80);
      push_item(KIND_WRITE, 1'b0, 1'b0, 8'h00, 8'h10, 8'h00);
      push_item(KIND_WRITE, 1'b0, 1'b1, 8'h00, 8'h20, 8'h00);
      push_item(KIND_READ, 1'b0, 1'b0, 8'h00, 8'h66, 8'h00);
      push_item(KIND_WRITE, 1'b0, 1'b1, 8'h00, 8'h77, 8'h00);
      push_item(KIND_READ, 1'b1, 1'b0, 8'h21, 8'h88, 8'h02);
      push_item(KIND_READ, 1'b1, 1'b1, 8'h21, 8'h99, 8'h00);
      push_item(KIND_READ, 1'b1, 1'b0, 8'hAA, 8'hBB, 8'h10);
      wait_idle();

      // The open transaction keeps its fault while checking is off.
      write_csr(crc8bpf_pkg::CsrCrcEnable, 8'hFE);
      write_csr(crc8bpf_pkg::CsrDeviceAddress, 8'h7F);
      push_item(KIND_WRITE, 1'b0, 1'b0, 8'h00, 8'hCC, 8'h3C);
      push_item(KIND_READ, 1'b0, 1'b1, 8'h00, 8'hDD, 8'hC3);
      push_item(KIND_READ, 1'b1, 1'b1, 8'hFF, 8'hEE, 8'h55);
      wait_idle();

      write_csr(crc8bpf_pkg::CsrCrcEnable, 8'h01);
      send_idle_pct = 27;
      recv_idle_pct = 84;
      queue_random_traffic(500);
      wait_idle();

      write_csr(crc8bpf_pkg::CsrDeviceAddress, 8'($urandom));
      write_csr(crc8bpf_pkg::CsrCrcEnable, {7'($urandom), 1'b0});
      send_idle_pct = 84;
      recv_idle_pct = 27;
      queue_random_traffic(300);
      wait_idle();

      write_csr(crc8bpf_pkg::CsrDeviceAddress, 8'($urandom));
      write_csr(crc8bpf_pkg::CsrCrcEnable, {7'($urandom), 1'b1});
      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_random_traffic(700);
      wait_idle();

      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
